// ===== sv/bpa_pkg.sv =====
package bpa_pkg;

   // default geometry
   localparam int PAGES_DEF     = 4096;
   localparam int TOP_ORDER_DEF = 10;

   // fixed field widths
   localparam int REQ_PAGES_W = 11;
   localparam int PAGE_W      = 12;
   localparam int ORDER_W     = 4;
   localparam int COUNT_W     = 13;

   localparam logic [COUNT_W-1:0] PAGE_COUNT_RST = COUNT_W'(4096);

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFREE  = 2'd1,
      ST_BADSIZE = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   // page kind codes
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ALLOC_TAIL = 2'd0;
   localparam kind_type KIND_FREE_HEAD  = 2'd1;
   localparam kind_type KIND_FREE_TAIL  = 2'd2;
   localparam kind_type KIND_ALLOC_HEAD = 2'd3;

   typedef struct packed {
      cmd_type                  cmd;
      logic [REQ_PAGES_W-1:0]   request_pages;
      logic [PAGE_W-1:0]        page_index;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [PAGE_W-1:0]        block_page;
      logic [ORDER_W-1:0]       block_order;
   } rsp_type;

   // per-field write enables of the link memory
   typedef struct packed {
      logic we_next;
      logic we_prev;
   } link_we_type;

endpackage

// ===== sv/buddy_page_allocator.sv =====
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  req_type: cmd, request_pages, page_index
// rsp      out        rsp_valid/rsp_stall  rsp_type: status, block_page, block_order
// csr      in         csr_valid/csr_ready  page_count, 13 bits
//
// One word at a time. Alloc cost grows with each split and with the 2^order page marks.
// Free cost grows with each merge and with the 2^order page marks.
// The cost is set by the page marking loop, one page memory write per cycle.
// After reset and after each csr write a carving pass over all PAGES pages runs;
// req is stalled during it. A result waiting on rsp_stall does not block
// acceptance of the next request.
module buddy_page_allocator import bpa_pkg::*; #(
   parameter int PAGES     = PAGES_DEF,
   parameter int TOP_ORDER = TOP_ORDER_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [COUNT_W-1:0]   csr_data
);

   localparam int AW = $clog2(PAGES);
   localparam int LW = $clog2(PAGES + 1);
   localparam int OW = $clog2(TOP_ORDER + 1);
   localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
   localparam logic [LW-1:0] NIL = LW'(PAGES);
   localparam logic [OW-1:0] TOP = OW'(TOP_ORDER);

   typedef enum logic [3:0] {
      S_IDLE, S_SWEEP, S_CHK, S_ARD, S_AUNL, S_SPLIT, S_PUSH, S_PUSH2,
      S_MARK, S_FRD, S_MERGE, S_MCHK, S_MUNL2, S_DONE
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   page_count_ff;
   logic                 ready_ff;
   logic [LW-1:0]        head_list_ff [TOP_ORDER+1];
   req_type              req_ff;
   logic [OW-1:0]        cur_ff, want_ff, ord_ff, mk_ord_ff;
   logic [AW-1:0]        head_ff, page_ff, mk_head_ff;
   logic [LW-1:0]        first_ff, scr_ff, mk_ptr_ff, mk_end_ff;
   logic [LW-1:0]        sw_i_ff, sw_s_ff;
   logic                 mk_free_ff, final_ff;
   status_type           status_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   // memory ports
   logic                 pg_we;
   logic [AW-1:0]        pg_waddr, pg_raddr;
   logic [OW-1:0]        pg_word, pg_rorder;
   kind_type             pg_wkind, pg_rkind;
   link_we_type          ln_we;
   logic [AW-1:0]        ln_waddr, ln_raddr;
   logic [LW-1:0]        ln_wnext, ln_wprev, ln_rnext, ln_rprev;

   logic [LW-1:0]        n_pages;
   logic [OW-1:0]        cv_ord, want, fnd_cur;
   logic                 found, bad_size;
   logic [AW-1:0]        buddy;
   logic                 merge_ok;

   bpa_page_mem #(.PAGES(PAGES), .OW(OW), .AW(AW)) u_page_mem (
      .clock    (clock),
      .wr_en    (pg_we),
      .wr_addr  (pg_waddr),
      .wr_order (pg_word),
      .wr_kind  (pg_wkind),
      .rd_addr  (pg_raddr),
      .rd_order (pg_rorder),
      .rd_kind  (pg_rkind)
   );

   bpa_link_mem #(.PAGES(PAGES), .AW(AW), .LW(LW)) u_link_mem (
      .clock   (clock),
      .wr_we   (ln_we),
      .wr_addr (ln_waddr),
      .wr_next (ln_wnext),
      .wr_prev (ln_wprev),
      .rd_addr (ln_raddr),
      .rd_next (ln_rnext),
      .rd_prev (ln_rprev)
   );

   // effective page count
   always_comb begin
      if (CW'(page_count_ff) < CW'(PAGES)) begin
         n_pages = LW'(page_count_ff);
      end else begin
         n_pages = NIL;
      end
   end

   // largest aligned block that fits at the sweep position
   always_comb begin
      cv_ord = '0;
      for (int o = 0; o <= TOP_ORDER; o++) begin
         if (((32'(sw_i_ff) & ((32'(1) << o) - 32'(1))) == 32'(0)) &&
             ((32'(1) << o) <= (32'(n_pages) - 32'(sw_i_ff)))) begin
            cv_ord = OW'(o);
         end
      end
   end

   // request size rounded up to an order
   always_comb begin
      want = TOP;
      for (int w = TOP_ORDER; w >= 0; w--) begin
         if ((32'(1) << w) >= 32'(req_ff.request_pages)) begin
            want = OW'(w);
         end
      end
      bad_size = (req_ff.request_pages == '0) ||
                 (32'(req_ff.request_pages) > (32'(1) << TOP_ORDER));
   end

   // smallest non-empty list at or above the wanted order
   always_comb begin
      found   = 1'b0;
      fnd_cur = '0;
      for (int c = TOP_ORDER; c >= 0; c--) begin
         if ((c >= int'(want)) && (head_list_ff[c] != NIL)) begin
            found   = 1'b1;
            fnd_cur = OW'(c);
         end
      end
   end

   assign buddy    = head_ff ^ AW'(32'(1) << ord_ff);
   assign merge_ok = (pg_rkind == KIND_FREE_HEAD) && (pg_rorder == ord_ff);

   // page memory write
   always_comb begin
      pg_we    = 1'b0;
      pg_waddr = mk_ptr_ff[AW-1:0];
      pg_word  = '0;
      pg_wkind = KIND_ALLOC_TAIL;
      case (state_ff)
         S_SWEEP: begin
            pg_we    = 1'b1;
            pg_waddr = sw_i_ff[AW-1:0];
            if (sw_i_ff < n_pages) begin
               if (sw_i_ff == sw_s_ff) begin
                  pg_word  = cv_ord;
                  pg_wkind = KIND_FREE_HEAD;
               end else begin
                  pg_wkind = KIND_FREE_TAIL;
               end
            end
         end
         S_MARK: begin
            pg_we = 1'b1;
            if (mk_ptr_ff[AW-1:0] == mk_head_ff) begin
               pg_word  = mk_ord_ff;
               pg_wkind = mk_free_ff ? KIND_FREE_HEAD : KIND_ALLOC_HEAD;
            end else begin
               pg_wkind = mk_free_ff ? KIND_FREE_TAIL : KIND_ALLOC_TAIL;
            end
         end
         default: ;
      endcase
   end

   // link memory write
   always_comb begin
      ln_we    = '0;
      ln_waddr = page_ff;
      ln_wnext = NIL;
      ln_wprev = NIL;
      case (state_ff)
         S_SWEEP: begin
            ln_we    = '{we_next: 1'b1, we_prev: 1'b1};
            ln_waddr = sw_i_ff[AW-1:0];
            if ((sw_i_ff < n_pages) && (sw_i_ff == sw_s_ff) && (cv_ord == TOP)) begin
               if (32'(sw_i_ff) >= (32'(1) << TOP_ORDER)) begin
                  ln_wnext = LW'(32'(sw_i_ff) - (32'(1) << TOP_ORDER));
               end
               if ((32'(sw_i_ff) + (32'(2) << TOP_ORDER)) <= 32'(n_pages)) begin
                  ln_wprev = LW'(32'(sw_i_ff) + (32'(1) << TOP_ORDER));
               end
            end
         end
         S_AUNL: begin
            if (ln_rnext != NIL) begin
               ln_we.we_prev = 1'b1;
               ln_waddr      = ln_rnext[AW-1:0];
            end
         end
         S_MCHK: begin
            if (merge_ok && (ln_rprev != NIL)) begin
               ln_we.we_next = 1'b1;
               ln_waddr      = ln_rprev[AW-1:0];
               ln_wnext      = ln_rnext;
            end
         end
         S_MUNL2: begin
            if (first_ff != NIL) begin
               ln_we.we_prev = 1'b1;
               ln_waddr      = first_ff[AW-1:0];
               ln_wprev      = scr_ff;
            end
         end
         S_PUSH: begin
            ln_we    = '{we_next: 1'b1, we_prev: 1'b1};
            ln_waddr = page_ff;
            ln_wnext = head_list_ff[ord_ff];
         end
         S_PUSH2: begin
            if (first_ff != NIL) begin
               ln_we.we_prev = 1'b1;
               ln_waddr      = first_ff[AW-1:0];
               ln_wprev      = LW'(page_ff);
            end
         end
         default: ;
      endcase
   end

   // read addresses
   always_comb begin
      pg_raddr = buddy;
      ln_raddr = buddy;
      case (state_ff)
         S_CHK: pg_raddr = AW'(req_ff.page_index);
         S_ARD: ln_raddr = head_ff;
         default: ;
      endcase
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         page_count_ff <= PAGE_COUNT_RST;
         ready_ff      <= 1'b0;
         sw_i_ff       <= '0;
         sw_s_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k <= TOP_ORDER; k++) begin
            head_list_ff[k] <= NIL;
         end
      end else begin
         // result register drains independently, unless reloaded below
         if (rsp_valid_ff && !rsp_stall && (csr_valid || (state_ff != S_DONE))) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            page_count_ff <= csr_data;
            ready_ff      <= 1'b0;
            sw_i_ff       <= '0;
            sw_s_ff       <= '0;
            state_ff      <= S_SWEEP;
            for (int k = 0; k <= TOP_ORDER; k++) begin
               head_list_ff[k] <= NIL;
            end
         end else begin
            case (state_ff)
               S_SWEEP: begin
                  if ((sw_i_ff < n_pages) && (sw_i_ff == sw_s_ff)) begin
                     head_list_ff[cv_ord] <= sw_i_ff;
                     sw_s_ff <= LW'(32'(sw_i_ff) + (32'(1) << cv_ord));
                  end
                  sw_i_ff <= sw_i_ff + LW'(1);
                  if (sw_i_ff == LW'(PAGES - 1)) begin
                     ready_ff <= (n_pages != '0);
                     state_ff <= S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (req_valid) begin
                     req_ff   <= req_data;
                     state_ff <= S_CHK;
                  end
               end
               S_CHK: begin
                  if (req_ff.cmd == CMD_ALLOC) begin
                     if (bad_size) begin
                        status_ff <= ST_BADSIZE;
                        state_ff  <= S_DONE;
                     end else if (!ready_ff || !found) begin
                        status_ff <= ST_NOFREE;
                        state_ff  <= S_DONE;
                     end else begin
                        status_ff <= ST_OK;
                        cur_ff   <= fnd_cur;
                        want_ff  <= want;
                        head_ff  <= head_list_ff[fnd_cur][AW-1:0];
                        state_ff <= S_ARD;
                     end
                  end else begin
                     if (!ready_ff || (32'(req_ff.page_index) >= 32'(n_pages))) begin
                        status_ff <= ST_IGNORED;
                        state_ff  <= S_DONE;
                     end else begin
                        status_ff <= ST_OK;
                        head_ff  <= AW'(req_ff.page_index);
                        state_ff <= S_FRD;
                     end
                  end
               end
               S_ARD: state_ff <= S_AUNL;
               S_AUNL: begin
                  head_list_ff[cur_ff] <= ln_rnext;
                  state_ff <= S_SPLIT;
               end
               S_SPLIT: begin
                  if (cur_ff > want_ff) begin
                     cur_ff   <= cur_ff - OW'(1);
                     ord_ff   <= cur_ff - OW'(1);
                     page_ff  <= AW'(32'(head_ff) + (32'(1) << (cur_ff - OW'(1))));
                     final_ff <= 1'b0;
                     state_ff <= S_PUSH;
                  end else begin
                     mk_ptr_ff  <= LW'(head_ff);
                     mk_head_ff <= head_ff;
                     mk_ord_ff  <= want_ff;
                     mk_free_ff <= 1'b0;
                     mk_end_ff  <= LW'(((32'(head_ff) + (32'(1) << want_ff)) <
                                         32'(PAGES)) ?
                                        (32'(head_ff) + (32'(1) << want_ff)) :
                                        32'(PAGES));
                     final_ff   <= 1'b1;
                     state_ff   <= S_MARK;
                  end
               end
               S_PUSH: begin
                  first_ff              <= head_list_ff[ord_ff];
                  head_list_ff[ord_ff]  <= LW'(page_ff);
                  state_ff              <= S_PUSH2;
               end
               S_PUSH2: begin
                  mk_ptr_ff  <= LW'(page_ff);
                  mk_head_ff <= page_ff;
                  mk_ord_ff  <= ord_ff;
                  mk_free_ff <= 1'b1;
                  mk_end_ff  <= LW'(((32'(page_ff) + (32'(1) << ord_ff)) <
                                      32'(PAGES)) ?
                                     (32'(page_ff) + (32'(1) << ord_ff)) :
                                     32'(PAGES));
                  state_ff   <= S_MARK;
               end
               S_MARK: begin
                  mk_ptr_ff <= mk_ptr_ff + LW'(1);
                  if ((mk_ptr_ff + LW'(1)) >= mk_end_ff) begin
                     state_ff <= final_ff ? S_DONE : S_SPLIT;
                  end
               end
               S_FRD: begin
                  if (pg_rkind != KIND_ALLOC_HEAD) begin
                     status_ff <= ST_IGNORED;
                     state_ff  <= S_DONE;
                  end else begin
                     ord_ff   <= (pg_rorder > TOP) ? TOP : pg_rorder;
                     state_ff <= S_MERGE;
                  end
               end
               S_MERGE: begin
                  if ((ord_ff == TOP) || (LW'(buddy) >= n_pages)) begin
                     page_ff  <= head_ff;
                     final_ff <= 1'b1;
                     state_ff <= S_PUSH;
                  end else begin
                     page_ff  <= buddy;
                     state_ff <= S_MCHK;
                  end
               end
               S_MCHK: begin
                  if (merge_ok) begin
                     if (ln_rprev == NIL) begin
                        head_list_ff[ord_ff] <= ln_rnext;
                     end
                     first_ff <= ln_rnext;
                     scr_ff   <= ln_rprev;
                     if (page_ff < head_ff) begin
                        head_ff <= page_ff;
                     end
                     ord_ff   <= ord_ff + OW'(1);
                     state_ff <= S_MUNL2;
                  end else begin
                     page_ff  <= head_ff;
                     final_ff <= 1'b1;
                     state_ff <= S_PUSH;
                  end
               end
               S_MUNL2: state_ff <= S_MERGE;
               S_DONE: begin
                  if (!rsp_valid_ff || !rsp_stall) begin
                     rsp_valid_ff       <= 1'b1;
                     rsp_ff.status      <= status_ff;
                     rsp_ff.block_page  <= (status_ff == ST_OK) ? PAGE_W'(head_ff) : '0;
                     rsp_ff.block_order <= (status_ff != ST_OK) ? '0 :
                                           (req_ff.cmd == CMD_ALLOC) ?
                                           ORDER_W'(want_ff) : ORDER_W'(ord_ff);
                     state_ff <= S_IDLE;
                  end
               end
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_sweep_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> !ready_ff)
      else $error("lists marked ready during carving");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (mk_ptr_ff < NIL))
      else $error("page mark outside page table");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != ST_OK)) |->
      ((rsp_ff.block_page == '0) && (rsp_ff.block_order == '0)))
      else $error("failed result carries a block");

   a_order_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (ord_ff <= TOP))
      else $error("merge order above top order");
`endif

endmodule

// ===== sv/bpa_page_mem.sv =====
module bpa_page_mem import bpa_pkg::*; #(
   parameter int PAGES = PAGES_DEF,
   parameter int OW    = 4,
   parameter int AW    = $clog2(PAGES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [OW-1:0] wr_order,
   input  kind_type      wr_kind,
   input  logic [AW-1:0] rd_addr,
   output logic [OW-1:0] rd_order,
   output kind_type      rd_kind
);

   logic [OW+1:0] mem [PAGES];
   logic [OW+1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_order, wr_kind};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_order = rd_data_ff[OW+1:2];
   assign rd_kind  = rd_data_ff[1:0];

endmodule

// ===== sv/bpa_link_mem.sv =====
module bpa_link_mem import bpa_pkg::*; #(
   parameter int PAGES = PAGES_DEF,
   parameter int AW    = $clog2(PAGES),
   parameter int LW    = $clog2(PAGES + 1)
) (
   input  logic          clock,
   input  link_we_type   wr_we,
   input  logic [AW-1:0] wr_addr,
   input  logic [LW-1:0] wr_next,
   input  logic [LW-1:0] wr_prev,
   input  logic [AW-1:0] rd_addr,
   output logic [LW-1:0] rd_next,
   output logic [LW-1:0] rd_prev
);

   logic [LW-1:0] next_mem [PAGES];
   logic [LW-1:0] prev_mem [PAGES];
   logic [LW-1:0] rd_next_ff;
   logic [LW-1:0] rd_prev_ff;

   // field-enabled write, registered read
   always_ff @(posedge clock) begin
      if (wr_we.we_next) begin
         next_mem[wr_addr] <= wr_next;
      end
      if (wr_we.we_prev) begin
         prev_mem[wr_addr] <= wr_prev;
      end
      rd_next_ff <= next_mem[rd_addr];
      rd_prev_ff <= prev_mem[rd_addr];
   end

   assign rd_next = rd_next_ff;
   assign rd_prev = rd_prev_ff;

endmodule
